// ===== rtl/core/hbk_pkg.sv =====
`default_nettype none

package hbk_pkg;

	// report layout
	localparam int MAX_SLOTS = 6;
	localparam int CODE_W = 8;
	localparam int CHAR_W = 7;
	localparam int LEN_W = 7;

	// translation limits
	localparam int MAP_ENTRIES = 104;
	localparam int TABLE_SIZE = 64;

	localparam logic [CODE_W-1:0] SHIFT_MASK = 8'h22;
	localparam logic [CODE_W-1:0] CODE_NONE = 8'h00;
	localparam logic [CODE_W-1:0] CODE_RIGHT_ARROW = 8'h4F;
	localparam logic [CODE_W-1:0] CODE_LEFT_ARROW = 8'h50;
	localparam logic [LEN_W-1:0] FULL_REPORT_LEN = 7'd8;

	localparam logic [CHAR_W-1:0] CHAR_NONE = 7'd0;
	localparam logic [CHAR_W-1:0] CHAR_LEFT = 7'd1;
	localparam logic [CHAR_W-1:0] CHAR_RIGHT = 7'd2;

	typedef logic [CODE_W-1:0] key_code_t;
	typedef logic [CHAR_W-1:0] key_char_t;

	// us keyboard usage code to ascii, zero where nothing is printed
	function automatic key_char_t map_char(key_code_t code, logic shifted);
		key_char_t c;
		logic [5:0] idx;
		c = CHAR_NONE;
		idx = code[5:0];
		if (code == CODE_RIGHT_ARROW) begin
			c = CHAR_RIGHT;
		end else if (code == CODE_LEFT_ARROW) begin
			c = CHAR_LEFT;
		end else if (int'(code) >= MAP_ENTRIES || int'(code) >= TABLE_SIZE) begin
			c = CHAR_NONE;
		end else if (idx >= 6'd4 && idx <= 6'd29) begin
			// letters a through z
			c = (shifted ? 7'h41 : 7'h61) + 7'(idx - 6'd4);
		end else if (!shifted && idx >= 6'd30 && idx <= 6'd38) begin
			// digits 1 through 9
			c = 7'h31 + 7'(idx - 6'd30);
		end else begin
			unique case (idx)
				6'd30: c = shifted ? 7'd33 : 7'd49;
				6'd31: c = 7'd64;
				6'd32: c = 7'd35;
				6'd33: c = 7'd36;
				6'd34: c = 7'd37;
				6'd35: c = 7'd94;
				6'd36: c = 7'd38;
				6'd37: c = 7'd42;
				6'd38: c = 7'd40;
				6'd39: c = shifted ? 7'd41 : 7'd48;
				6'd40: c = 7'd10;
				6'd41: c = 7'd27;
				6'd42: c = 7'd8;
				6'd43: c = 7'd9;
				6'd44: c = 7'd32;
				6'd45: c = shifted ? 7'd95 : 7'd45;
				6'd46: c = shifted ? 7'd43 : 7'd61;
				6'd47: c = shifted ? 7'd123 : 7'd91;
				6'd48: c = shifted ? 7'd125 : 7'd93;
				6'd49: c = shifted ? 7'd124 : 7'd92;
				6'd51: c = shifted ? 7'd58 : 7'd59;
				6'd52: c = shifted ? 7'd34 : 7'd39;
				6'd53: c = shifted ? 7'd126 : 7'd96;
				6'd54: c = shifted ? 7'd60 : 7'd44;
				6'd55: c = shifted ? 7'd62 : 7'd46;
				6'd56: c = shifted ? 7'd63 : 7'd47;
				default: c = CHAR_NONE;
			endcase
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hbk_report_if.sv =====
`default_nettype none

interface hbk_report_if;

	logic valid;
	logic ready;
	logic [7:0] modifiers;
	logic [7:0] key_code_0;
	logic [7:0] key_code_1;
	logic [7:0] key_code_2;
	logic [7:0] key_code_3;
	logic [7:0] key_code_4;
	logic [7:0] key_code_5;
	logic [6:0] report_length;

	modport source (
		output valid, modifiers, key_code_0, key_code_1, key_code_2,
		key_code_3, key_code_4, key_code_5, report_length,
		input ready
	);

	modport sink (
		input valid, modifiers, key_code_0, key_code_1, key_code_2,
		key_code_3, key_code_4, key_code_5, report_length,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/core/hbk_char_if.sv =====
`default_nettype none

interface hbk_char_if;

	logic valid;
	logic ready;
	logic [6:0] key_char;
	logic last_of_report;

	modport source (
		output valid, key_char, last_of_report,
		input ready
	);

	modport sink (
		input valid, key_char, last_of_report,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/core/hbk_scan.sv =====
`default_nettype none

module hbk_scan #(
	parameter int KEY_SLOTS = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	hbk_report_if.sink report,
	input wire logic slot_free,
	output logic load,
	output logic [KEY_SLOTS-1:0] fresh,
	output hbk_pkg::key_char_t fresh_char [KEY_SLOTS]
);

	hbk_pkg::key_code_t codes [hbk_pkg::MAX_SLOTS];
	logic [KEY_SLOTS-1:0][hbk_pkg::CODE_W-1:0] prev_keys_q;
	logic accept;
	logic full;
	logic shifted;

	// report slots as an array
	assign codes[0] = report.key_code_0;
	assign codes[1] = report.key_code_1;
	assign codes[2] = report.key_code_2;
	assign codes[3] = report.key_code_3;
	assign codes[4] = report.key_code_4;
	assign codes[5] = report.key_code_5;

	// take a report whenever the character buffer can hold its batch
	assign report.ready = slot_free;
	assign accept = report.valid && report.ready;
	assign full = report.report_length >= hbk_pkg::FULL_REPORT_LEN;
	assign load = accept && full;
	assign shifted = |(report.modifiers & hbk_pkg::SHIFT_MASK);

	// per slot: new since last full report and printable
	always_comb begin
		logic held;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			held = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (prev_keys_q[j] == codes[i]) begin
					held = 1'b1;
				end
			end
			fresh_char[i] = hbk_pkg::map_char(codes[i], shifted);
			fresh[i] = (codes[i] != hbk_pkg::CODE_NONE) && !held
				&& (fresh_char[i] != hbk_pkg::CHAR_NONE);
		end
	end

	// key codes of the last full report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q <= '0;
		end else if (load) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= codes[i];
			end
		end
	end

	// a short report leaves the held keys alone
	a_short_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !full |=> $stable(prev_keys_q))
		else $error("held keys changed on a short report");

endmodule

`default_nettype wire

// ===== rtl/core/hbk_emit.sv =====
`default_nettype none

module hbk_emit #(
	parameter int KEY_SLOTS = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire logic [KEY_SLOTS-1:0] fresh,
	input wire hbk_pkg::key_char_t fresh_char [KEY_SLOTS],
	output logic slot_free,
	hbk_char_if.source chars
);

	logic [KEY_SLOTS-1:0] pend_s1;
	hbk_pkg::key_char_t char_s1 [KEY_SLOTS];
	logic out_valid_q;
	hbk_pkg::key_char_t key_char_q;
	logic last_q;
	logic out_free;
	logic emit_fire;
	logic [KEY_SLOTS-1:0] pick;
	logic [KEY_SLOTS-1:0] rest;
	hbk_pkg::key_char_t sel_char;

	// lowest pending slot goes out first
	assign out_free = !out_valid_q || chars.ready;
	assign emit_fire = (pend_s1 != '0) && out_free;
	assign pick = pend_s1 & (~pend_s1 + 1'b1);
	assign rest = pend_s1 & ~pick;
	assign slot_free = emit_fire ? (rest == '0) : (pend_s1 == '0);

	always_comb begin
		sel_char = hbk_pkg::CHAR_NONE;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			sel_char = sel_char | (char_s1[i] & {hbk_pkg::CHAR_W{pick[i]}});
		end
	end

	// batch of pending characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (load) begin
			pend_s1 <= fresh;
		end else if (emit_fire) begin
			pend_s1 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_s1 <= fresh_char;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			key_char_q <= sel_char;
			last_q <= (rest == '0);
		end
	end

	assign chars.valid = out_valid_q;
	assign chars.key_char = key_char_q;
	assign chars.last_of_report = last_q;

	// a beat never carries an empty character
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid |-> chars.key_char != hbk_pkg::CHAR_NONE)
		else $error("empty character on output");

	// more characters remain after a beat not marked last
	a_more_after_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire && rest != '0 |=> pend_s1 != '0)
		else $error("pending characters lost");

	// nothing pending after the last beat of a batch
	a_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire && rest == '0 && !load |=> pend_s1 == '0)
		else $error("stray character after last of report");

endmodule

`default_nettype wire

// ===== rtl/core/hid_boot_keyboard_to_ascii_unit.sv =====
`default_nettype none

// Boot keyboard report to ascii. Each full report (length 8 or more) is compared
// with the key codes of the previous full report; every slot that holds a newly
// pressed key with a printable mapping (us layout, shift from either shift bit,
// arrows as 1 and 2) gives one character beat, in slot order, the final one marked
// last_of_report. Short reports are accepted and dropped. Characters of an accepted
// report go to the batch register and then leave one per cycle from the output
// register while the output is ready, and the next report is accepted in the cycle
// its last character moves to the output.
// KEY_SLOTS (1 to 6) limits how many slots are examined and stored.
module hid_boot_keyboard_to_ascii_unit #(
	parameter int KEY_SLOTS = 6
) (
	input wire logic clk,
	input wire logic arst_n,
	hbk_report_if.sink report,
	hbk_char_if.source chars
);

	logic slot_free;
	logic load;
	logic [KEY_SLOTS-1:0] fresh;
	hbk_pkg::key_char_t fresh_char [KEY_SLOTS];

	// compare against held keys and translate
	hbk_scan #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.report(report),
		.slot_free(slot_free),
		.load(load),
		.fresh(fresh),
		.fresh_char(fresh_char)
	);

	// hand out characters one beat at a time
	hbk_emit #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.fresh(fresh),
		.fresh_char(fresh_char),
		.slot_free(slot_free),
		.chars(chars)
	);

endmodule

`default_nettype wire

// ===== tb/hid_boot_keyboard_to_ascii_unit_tb.sv =====
`default_nettype none

typedef struct packed {
	logic [hbk_pkg::CODE_W-1:0] modifiers;
	hbk_pkg::key_code_t [hbk_pkg::MAX_SLOTS-1:0] codes;
	logic [hbk_pkg::LEN_W-1:0] length;
} report_beat_t;

typedef struct {
	hbk_pkg::key_char_t ch;
	logic last;
} char_beat_t;

// tracks held keys and the characters each report should produce
class key_char_tracker;
	localparam int CODE_A = 4;
	localparam int CODE_ZERO = 39;
	localparam int CODE_ENTER = 40;
	localparam int CODE_ESCAPE = 41;
	localparam int CODE_BACKSPACE = 42;
	localparam int CODE_TAB = 43;
	localparam int CODE_SPACE = 44;
	localparam int CODE_MINUS = 45;
	localparam int CODE_NON_US_HASH = 50;
	localparam int CODE_SLASH = 56;

	localparam string LOWER_KEYS = "abcdefghijklmnopqrstuvwxyz1234567890";
	localparam string UPPER_KEYS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()";
	// position of the non-us hash key is a filler, it never prints
	localparam string LOWER_PUNCT = "-=[]\\ ;'`,./";
	localparam string UPPER_PUNCT = "_+{}| :\"~<>?";

	hbk_pkg::key_code_t held_keys[hbk_pkg::MAX_SLOTS];
	char_beat_t pending_chars[$];
	int errors;

	function new();
		foreach (held_keys[i]) held_keys[i] = hbk_pkg::CODE_NONE;
		errors = 0;
	endfunction

	function hbk_pkg::key_char_t lookup(hbk_pkg::key_code_t code, logic shifted);
		hbk_pkg::key_char_t c;
		int n;
		c = hbk_pkg::CHAR_NONE;
		n = int'(code);
		if (code == hbk_pkg::CODE_RIGHT_ARROW) begin
			c = hbk_pkg::CHAR_RIGHT;
		end else if (code == hbk_pkg::CODE_LEFT_ARROW) begin
			c = hbk_pkg::CHAR_LEFT;
		end else if (n >= CODE_A && n <= CODE_ZERO) begin
			c = hbk_pkg::key_char_t'(shifted ? UPPER_KEYS[n - CODE_A] :
				LOWER_KEYS[n - CODE_A]);
		end else if (n >= CODE_MINUS && n <= CODE_SLASH && n != CODE_NON_US_HASH) begin
			c = hbk_pkg::key_char_t'(shifted ? UPPER_PUNCT[n - CODE_MINUS] :
				LOWER_PUNCT[n - CODE_MINUS]);
		end else begin
			case (n)
				CODE_ENTER: c = 7'd10;
				CODE_ESCAPE: c = 7'd27;
				CODE_BACKSPACE: c = 7'd8;
				CODE_TAB: c = 7'd9;
				CODE_SPACE: c = 7'd32;
				default: c = hbk_pkg::CHAR_NONE;
			endcase
		end
		return c;
	endfunction

	function void note_report(report_beat_t r);
		logic shifted;
		logic seen;
		hbk_pkg::key_char_t c;
		char_beat_t b;
		int first;
		if (r.length < hbk_pkg::FULL_REPORT_LEN) return;
		shifted = (r.modifiers & hbk_pkg::SHIFT_MASK) != '0;
		first = pending_chars.size();
		for (int i = 0; i < hbk_pkg::MAX_SLOTS; i++) begin
			if (r.codes[i] == hbk_pkg::CODE_NONE) continue;
			seen = 1'b0;
			foreach (held_keys[j]) if (held_keys[j] == r.codes[i]) seen = 1'b1;
			if (seen) continue;
			c = lookup(r.codes[i], shifted);
			if (c == hbk_pkg::CHAR_NONE) continue;
			b.ch = c;
			b.last = 1'b0;
			pending_chars.push_back(b);
		end
		if (pending_chars.size() > first) pending_chars[$].last = 1'b1;
		for (int i = 0; i < hbk_pkg::MAX_SLOTS; i++) held_keys[i] = r.codes[i];
	endfunction

	function void check_char(hbk_pkg::key_char_t ch, logic last);
		char_beat_t b;
		if (pending_chars.size() == 0) begin
			$display("%0t: unexpected char beat, expected none, got char %0d last %0b",
				$time, ch, last);
			errors++;
			return;
		end
		b = pending_chars.pop_front();
		if (ch !== b.ch) begin
			$display("%0t: key_char expected %0d got %0d", $time, b.ch, ch);
			errors++;
		end
		if (last !== b.last) begin
			$display("%0t: last_of_report expected %0b got %0b", $time, b.last, last);
			errors++;
		end
	endfunction

	function int pending();
		return pending_chars.size();
	endfunction
endclass

module hid_boot_keyboard_to_ascii_unit_tb;

	localparam int RANDOM_REPORTS = 290;
	localparam int CALM_TAIL = 40;
	localparam int STALL_AT = 120;
	localparam int LONG_STALL = 80;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;
	logic idling;
	logic hold_output;
	int idle_cycles;

	hbk_report_if report();
	hbk_char_if chars();

	key_char_tracker tracker = new();

	hid_boot_keyboard_to_ascii_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.report(report),
		.chars(chars)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// offer one report and wait for its beat
	task automatic send_report(input report_beat_t r);
		if (idling && $urandom_range(0, 3) == 0) begin
			report.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		report.valid <= 1'b1;
		report.modifiers <= r.modifiers;
		report.key_code_0 <= r.codes[0];
		report.key_code_1 <= r.codes[1];
		report.key_code_2 <= r.codes[2];
		report.key_code_3 <= r.codes[3];
		report.key_code_4 <= r.codes[4];
		report.key_code_5 <= r.codes[5];
		report.report_length <= r.length;
		do @(posedge clk); while (!report.ready);
	endtask

	function automatic report_beat_t make_report(logic [7:0] mods,
			hbk_pkg::key_code_t c0, hbk_pkg::key_code_t c1, hbk_pkg::key_code_t c2,
			hbk_pkg::key_code_t c3, hbk_pkg::key_code_t c4, hbk_pkg::key_code_t c5,
			logic [hbk_pkg::LEN_W-1:0] len);
		report_beat_t r;
		r.modifiers = mods;
		r.codes = {c5, c4, c3, c2, c1, c0};
		r.length = len;
		return r;
	endfunction

	// mostly printable keys, some arrows, empties, junk and keys still held
	function automatic hbk_pkg::key_code_t pick_code(hbk_pkg::key_code_t held);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return hbk_pkg::key_code_t'($urandom_range(4, 56));
		if (roll < 65) begin
			return $urandom_range(0, 1) ? hbk_pkg::CODE_RIGHT_ARROW :
				hbk_pkg::CODE_LEFT_ARROW;
		end
		if (roll < 80) return hbk_pkg::CODE_NONE;
		if (roll < 90) return hbk_pkg::key_code_t'($urandom_range(0, 255));
		return held;
	endfunction

	// output side readiness, with one long hold-off
	initial begin
		int n;
		chars.ready = 1'b0;
		@(posedge clk);
		wait (arst_n === 1'b1);
		forever begin
			if (hold_output) begin
				hold_output = 1'b0;
				chars.ready <= 1'b0;
				n = LONG_STALL;
			end else if (idling && $urandom_range(0, 3) == 0) begin
				chars.ready <= 1'b0;
				n = $urandom_range(1, 12);
			end else begin
				chars.ready <= 1'b1;
				n = $urandom_range(1, 20);
			end
			repeat (n) @(posedge clk);
		end
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (report.valid && report.ready) begin
				tracker.note_report({report.modifiers, report.key_code_5, report.key_code_4,
					report.key_code_3, report.key_code_2, report.key_code_1,
					report.key_code_0, report.report_length});
			end
			if (chars.valid && chars.ready) begin
				tracker.check_char(chars.key_char, chars.last_of_report);
			end
			if ((report.valid && report.ready) || (chars.valid && chars.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("hid_boot_keyboard_to_ascii_unit: mismatch");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// reset, directed reports, random reports, drain
	initial begin
		report_beat_t r;
		report_beat_t prev;
		idle_cycles = 0;
		idling = 1'b1;
		hold_output = 1'b0;
		arst_n = 1'b0;
		report.valid = 1'b0;
		report.modifiers = '0;
		report.key_code_0 = '0;
		report.key_code_1 = '0;
		report.key_code_2 = '0;
		report.key_code_3 = '0;
		report.key_code_4 = '0;
		report.key_code_5 = '0;
		report.report_length = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty report, plain letters, held keys, short reports
		send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));
		send_report(make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 7'd8));
		send_report(make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h00, 8'h00, 7'd8));
		send_report(make_report(8'h00, 8'h08, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 7'd7));
		send_report(make_report(8'hFF, 8'hFF, 8'h0A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd0));
		// shifted digits by left and right shift
		send_report(make_report(8'h02, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 7'd8));
		send_report(make_report(8'h20, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 7'd8));
		// control keys, other modifier bits, long reports
		send_report(make_report(8'hDD, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h32, 7'd64));
		send_report(make_report(8'hFF, 8'h2F, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 7'd127));
		send_report(make_report(8'h00, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3F, 7'd8));
		// arrows and codes beyond the map
		send_report(make_report(8'h00, 8'h4F, 8'h50, 8'h67, 8'h68, 8'hFF, 8'h80, 7'd8));
		// one new key repeated in every slot, then held
		send_report(make_report(8'h00, 8'h1D, 8'h1D, 8'h1D, 8'h1D, 8'h1D, 8'h1D, 7'd8));
		send_report(make_report(8'h22, 8'h1D, 8'h1D, 8'h1D, 8'h1D, 8'h1D, 8'h1D, 7'd9));
		send_report(make_report(8'h00, 8'h01, 8'h02, 8'h03, 8'h40, 8'h63, 8'h64, 7'd8));
		send_report(make_report(8'h00, 8'h50, 8'h4F, 8'h00, 8'h00, 8'h04, 8'h00, 7'd8));
		send_report(make_report(8'h22, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 7'd8));
		send_report(make_report(8'h01, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 7'd8));
		send_report(make_report(8'h00, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 7'd8));
		send_report(make_report(8'h00, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 7'd8));
		send_report(make_report(8'h00, 8'h1C, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 7'd8));
		send_report(make_report(8'h00, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 7'd8));
		send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8));

		// random reports, mostly full, keys often carried over
		prev = make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd8);
		for (int i = 0; i < RANDOM_REPORTS; i++) begin
			if (i == STALL_AT) hold_output = 1'b1;
			if (i >= RANDOM_REPORTS - CALM_TAIL) idling = 1'b0;
			case ($urandom_range(0, 3))
				0: r.modifiers = 8'($urandom_range(0, 255));
				1: r.modifiers = 8'h02;
				2: r.modifiers = 8'h20;
				default: r.modifiers = 8'h00;
			endcase
			for (int s = 0; s < hbk_pkg::MAX_SLOTS; s++) begin
				if ($urandom_range(0, 2) == 0) begin
					r.codes[s] = prev.codes[s];
				end else begin
					r.codes[s] = pick_code(prev.codes[$urandom_range(0,
						hbk_pkg::MAX_SLOTS - 1)]);
				end
			end
			if ($urandom_range(0, 99) < 85) r.length = hbk_pkg::FULL_REPORT_LEN;
			else r.length = (hbk_pkg::LEN_W)'($urandom_range(0, 127));
			send_report(r);
			if (r.length >= hbk_pkg::FULL_REPORT_LEN) prev = r;
		end
		report.valid <= 1'b0;

		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("hid_boot_keyboard_to_ascii_unit: match");
		end else begin
			$display("hid_boot_keyboard_to_ascii_unit: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
